@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the filter RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/iirdf1_pkg.sv @@
// Types and fixed constants of the direct-form-I IIR filter.
package iirdf1_pkg;

    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 4;
    localparam int TAP_COUNT_W = 5;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 32;
    localparam int OUT_W       = 32;
    localparam int ACC_W       = 64;
    localparam int PROD_W      = 2 * COEF_W;
    localparam int HIST_W      = OUT_W + SAMPLE_W;

    // b*x is .22, a*y is .30; accumulator is .16, output .8
    localparam int BX_SHIFT  = 6;
    localparam int AY_SHIFT  = 14;
    localparam int RND_SHIFT = 8;

    localparam logic [ACTION_W-1:0] ACT_FILTER  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FF_COEF = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FB_COEF = 2'd2;

endpackage

@@ hw/rtl/iirdf1_if.sv @@
// Stream interfaces for the filter's input and result channels.
interface iirdf1_in_if;
    import iirdf1_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, action, coef_index, coef_value, sample_in, input ready);
    modport sink   (input valid, action, coef_index, coef_value, sample_in, output ready);
endinterface

interface iirdf1_out_if;
    import iirdf1_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered_out;
    logic                    saturated;

    modport source (output valid, filtered_out, saturated, input ready);
    modport sink   (input valid, filtered_out, saturated, output ready);
endinterface

@@ hw/rtl/iirdf1_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module iirdf1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/iir_direct_form_one_filter.sv @@
// Top level of the direct-form-I IIR filter with one shared multiplier.
//
// Direct-form-I IIR filter. Each transfer on i_in carries an action: a filter
// action takes sample_in and yields one transfer on o_out,
//   y = b0*x + sum over k = 1 .. n-1 of (b[k]*x[-k] - a[k]*y[-k]),
// in signed Q24.8, rounded to nearest and clipped to 32 bits (saturated set
// when clipped). The two coefficient actions write b[coef_index] or
// a[coef_index] (signed Q10.22, a0 implied as 1) and yield nothing; indexes at
// or above MAX_TAPS and the unused action code are dropped. n is the tap_count
// register (written through i_cfg_we / i_cfg_wdata), with 0 read as 1 and
// values above MAX_TAPS read as MAX_TAPS. Taps and histories are zero after
// reset through per-entry valid bits, so there is no clearing pass; the
// histories carry over from sample to sample. A coefficient transfer leaves
// the block idle; a sample occupies it until its result is loaded, since the
// single 32x32 multiplier forms b[k]*x[-k] and a[k]*y[-k] of each tap one
// after the other, followed by the read, multiply and accumulate stages and
// the rounding step. i_in.ready is low meanwhile. A finished result sits in
// the output register until taken; coefficient transfers are still accepted
// then, and a following sample waits only at its final rounding step.
`include "assert_macros.svh"

module iir_direct_form_one_filter #(
    parameter int MAX_TAPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iirdf1_pkg::TAP_COUNT_W-1:0]  i_cfg_wdata,
    iirdf1_in_if.sink                           i_in,
    iirdf1_out_if.source                        o_out
);
    import iirdf1_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN
    } t_state;

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    t_state                   r_state;
    logic [TAP_COUNT_W-1:0]   r_tap_count;
    logic [AW-1:0]            r_k;        // tap being issued
    logic [AW-1:0]            r_last;     // last tap of this sample
    logic                     r_phase;    // 0: b*x, 1: a*y
    logic [AW-1:0]            r_hp;       // history address of tap r_k
    logic [AW-1:0]            r_wp;       // next history slot to write
    logic [MAX_TAPS-1:0]      r_bv;       // feedforward entry written
    logic [MAX_TAPS-1:0]      r_av;       // feedback entry written
    logic [MAX_TAPS-1:0]      r_hv;       // history slot written
    logic                     r_out_vld;
    logic signed [OUT_W-1:0]  r_out_y;
    logic                     r_out_sat;

    // pipeline: s1 = RAM data out, s2 = product register
    logic                     r_s1_vld;
    logic                     r_s1_phase;
    logic                     r_s1_k0;
    logic                     r_s1_bv;
    logic                     r_s1_av;
    logic                     r_s1_hv;
    logic                     r_s2_vld;
    logic                     r_s2_phase;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SAMPLE_W-1:0] r_x;

    // ---------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------
    logic xfer_in;
    logic is_filter;
    logic is_ff;
    logic is_fb;
    logic idx_ok;
    logic [AW-1:0] coef_addr;
    logic [AW-1:0] n_last;

    assign i_in.ready = (r_state == S_IDLE);
    assign xfer_in    = i_in.valid && i_in.ready;
    assign idx_ok     = (32'(i_in.coef_index) < MAX_TAPS);
    assign coef_addr  = AW'(i_in.coef_index);

    always_comb begin
        is_filter = 1'b0;
        is_ff     = 1'b0;
        is_fb     = 1'b0;
        unique case (i_in.action)
            ACT_FILTER:  is_filter = 1'b1;
            ACT_FF_COEF: is_ff     = 1'b1;
            ACT_FB_COEF: is_fb     = 1'b1;
            default:     ;     // unused code: dropped
        endcase
    end

    // tap count clamp: zero acts as one, large values as MAX_TAPS
    always_comb begin
        if (r_tap_count == '0) begin
            n_last = '0;
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            n_last = AW'(MAX_TAPS - 1);
        end else begin
            n_last = AW'(r_tap_count - 1'b1);
        end
    end

    // ---------------------------------------------------------------
    // coefficient and history memories
    // ---------------------------------------------------------------
    logic                    b_we;
    logic                    a_we;
    logic                    fin_go;
    logic [COEF_W-1:0]       b_rd;
    logic [COEF_W-1:0]       a_rd;
    logic [HIST_W-1:0]       h_rd;
    logic [HIST_W-1:0]       h_wdata;

    assign b_we = xfer_in && is_ff && idx_ok;
    assign a_we = xfer_in && is_fb && idx_ok;

    iirdf1_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_ff_taps (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (coef_addr),
        .i_wdata (i_in.coef_value),
        .i_raddr (r_k),
        .o_rdata (b_rd)
    );

    iirdf1_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_fb_taps (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (coef_addr),
        .i_wdata (i_in.coef_value),
        .i_raddr (r_k),
        .o_rdata (a_rd)
    );

    // history ring: {y, x} per slot, newest at r_wp - 1
    iirdf1_ram #(.WIDTH(HIST_W), .DEPTH(MAX_TAPS)) u_history (
        .i_clk   (i_clk),
        .i_we    (fin_go),
        .i_waddr (r_wp),
        .i_wdata (h_wdata),
        .i_raddr (r_hp),
        .o_rdata (h_rd)
    );

    // ---------------------------------------------------------------
    // shared multiplier: operand select at s1, product into s2
    // ---------------------------------------------------------------
    logic signed [COEF_W-1:0]  op_a;
    logic signed [COEF_W-1:0]  op_b;
    logic signed [COEF_W-1:0]  x_ext;
    logic signed [COEF_W-1:0]  xh_ext;
    logic signed [COEF_W-1:0]  yh;
    logic signed [PROD_W-1:0]  prod;

    assign x_ext  = {{(COEF_W - SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
    assign xh_ext = {{(COEF_W - SAMPLE_W){h_rd[SAMPLE_W-1]}}, h_rd[SAMPLE_W-1:0]};
    assign yh     = h_rd[HIST_W-1:SAMPLE_W];

    always_comb begin
        if (r_s1_phase) begin
            op_a = r_s1_av ? a_rd : '0;
            op_b = r_s1_hv ? yh : '0;
        end else begin
            op_a = r_s1_bv ? b_rd : '0;
            if (r_s1_k0) begin
                op_b = x_ext;
            end else begin
                op_b = r_s1_hv ? xh_ext : '0;
            end
        end
    end

    assign prod = op_a * op_b;

    // ---------------------------------------------------------------
    // accumulate: floor shift, subtract feedback, saturate at 64 bits
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] term;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  n_acc;

    assign term = r_s2_phase ? (r_prod >>> AY_SHIFT) : (r_prod >>> BX_SHIFT);

    always_comb begin
        if (r_s2_phase) begin
            acc_sum = {r_acc[ACC_W-1], r_acc} - {term[PROD_W-1], term};
        end else begin
            acc_sum = {r_acc[ACC_W-1], r_acc} + {term[PROD_W-1], term};
        end
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            n_acc = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_acc = acc_sum[ACC_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // rounding to .8 and clip to 32 bits
    // ---------------------------------------------------------------
    logic signed [ACC_W:0]   rnd_sum;
    logic signed [ACC_W-1:0] rnd;
    logic                    y_fits;
    logic signed [OUT_W-1:0] n_y;
    logic                    n_sat;

    assign rnd_sum = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(1 << (RND_SHIFT - 1));

    always_comb begin
        // only a positive overflow is possible here
        if (rnd_sum[ACC_W] != rnd_sum[ACC_W-1]) begin
            rnd = {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            rnd = rnd_sum[ACC_W-1:0];
        end
        y_fits = (&rnd[ACC_W-1:RND_SHIFT+OUT_W-1]) || !(|rnd[ACC_W-1:RND_SHIFT+OUT_W-1]);
        if (y_fits) begin
            n_y   = rnd[RND_SHIFT+OUT_W-1:RND_SHIFT];
            n_sat = 1'b0;
        end else begin
            n_y   = rnd[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            n_sat = 1'b1;
        end
    end

    assign fin_go  = (r_state == S_FIN) && (!r_out_vld || o_out.ready);
    assign h_wdata = {n_y, r_x};

    assign o_out.valid        = r_out_vld;
    assign o_out.filtered_out = r_out_y;
    assign o_out.saturated    = r_out_sat;

    // ---------------------------------------------------------------
    // sequencer, valid bits and output register
    // ---------------------------------------------------------------
    logic [AW-1:0] hp_dec;
    logic [AW-1:0] wp_inc;

    assign hp_dec = (r_hp == '0) ? AW'(MAX_TAPS - 1) : r_hp - 1'b1;
    assign wp_inc = (r_wp == AW'(MAX_TAPS - 1)) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= TAP_COUNT_W'(1);
            r_k         <= '0;
            r_last      <= '0;
            r_phase     <= 1'b0;
            r_hp        <= '0;
            r_wp        <= '0;
            r_bv        <= '0;
            r_av        <= '0;
            r_hv        <= '0;
            r_out_vld   <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
            if (b_we) begin
                r_bv[coef_addr] <= 1'b1;
            end
            if (a_we) begin
                r_av[coef_addr] <= 1'b1;
            end
            // a result loaded in the same cycle keeps the register full
            if (o_out.valid && o_out.ready && !fin_go) begin
                r_out_vld <= 1'b0;
            end

            r_s1_vld <= (r_state == S_RUN);
            r_s2_vld <= r_s1_vld;

            unique case (r_state)
                S_IDLE: begin
                    if (xfer_in && is_filter) begin
                        r_state <= S_RUN;
                        r_k     <= '0;
                        r_phase <= 1'b0;
                        r_last  <= n_last;
                        r_hp    <= (r_wp == '0) ? AW'(MAX_TAPS - 1) : r_wp - 1'b1;
                    end
                end
                S_RUN: begin
                    // tap 0 needs only b0*x; later taps take both phases
                    if (r_k == '0) begin
                        if (r_last == '0) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_k <= AW'(1);
                        end
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (r_k == r_last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_hp <= hp_dec;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_vld && !r_s2_vld) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_state       <= S_IDLE;
                        r_out_vld     <= 1'b1;
                        r_out_y       <= n_y;
                        r_out_sat     <= n_sat;
                        r_hv[r_wp]    <= 1'b1;
                        r_wp          <= wp_inc;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            r_s1_phase <= r_phase;
            r_s1_k0    <= (r_k == '0);
            r_s1_bv    <= r_bv[r_k];
            r_s1_av    <= r_av[r_k];
            r_s1_hv    <= r_hv[r_hp];
        end
        r_s2_phase <= r_s1_phase;
        r_prod     <= prod;
        if (xfer_in && is_filter) begin
            r_x   <= i_in.sample_in;
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= n_acc;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ASSERT_IMPLY(a_ready_pipe_empty, i_clk, i_rst_n, i_in.ready, !r_s1_vld && !r_s2_vld, "input ready while products in flight")
    `ASSERT_NEXT(a_sample_starts, i_clk, i_rst_n, xfer_in && (i_in.action == ACT_FILTER), r_state == S_RUN, "sample transfer did not start the sequencer")
    `ASSERT_IMPLY(a_tap_in_range, i_clk, i_rst_n, r_state == S_RUN, r_k <= r_last, "tap counter past last tap")
    `ASSERT_IMPLY(a_ptr_in_range, i_clk, i_rst_n, 1'b1, (32'(r_wp) < MAX_TAPS) && (32'(r_hp) < MAX_TAPS), "history pointer out of range")

endmodule
